/* sv/alu8_nzvc_flags_unit_macros.svh */
// Assertion helpers for the ALU block; clocked on clk, off while arst_n is low.
`ifndef ALU8_NZVC_FLAGS_UNIT_MACROS_SVH
`define ALU8_NZVC_FLAGS_UNIT_MACROS_SVH

// Same-cycle implication.
`define A8_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("alu8 check failed: same-cycle rule");

// Next-cycle implication.
`define A8_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("alu8 check failed: next-cycle rule");

`endif

/* sv/alu8nzvc_pkg.sv */
`default_nettype none

package alu8nzvc_pkg;

	localparam logic [3:0] MODE_ADD  = 4'd0;
	localparam logic [3:0] MODE_SUB  = 4'd1;
	localparam logic [3:0] MODE_AND  = 4'd2;
	localparam logic [3:0] MODE_OR   = 4'd3;
	localparam logic [3:0] MODE_XOR  = 4'd4;
	localparam logic [3:0] MODE_COM  = 4'd5;
	localparam logic [3:0] MODE_NEG  = 4'd6;
	localparam logic [3:0] MODE_SHL  = 4'd7;
	localparam logic [3:0] MODE_ASR  = 4'd8;
	localparam logic [3:0] MODE_ROL  = 4'd9;
	localparam logic [3:0] MODE_ROR  = 4'd10;
	localparam logic [3:0] MODE_TEST = 4'd11;

	localparam int FLAG_N_BIT = 3;
	localparam int FLAG_Z_BIT = 2;
	localparam int FLAG_V_BIT = 1;
	localparam int FLAG_C_BIT = 0;

	localparam logic [7:0] MOST_NEG = 8'h80;

	typedef struct packed {
		logic [3:0] mode;
		logic [7:0] a;
		logic [7:0] b;
		logic       cin;
	} op_t;

	typedef struct packed {
		logic [7:0] result;
		logic [3:0] flags;
	} res_t;

endpackage

`default_nettype wire

/* sv/alu8nzvc_core.sv */
`default_nettype none

module alu8nzvc_core (
	input  alu8nzvc_pkg::op_t  op,
	output alu8nzvc_pkg::res_t res
);
	import alu8nzvc_pkg::*;

	logic [8:0] sum;
	logic [8:0] diff;
	logic [7:0] r;
	logic       v;
	logic       c;

	assign sum  = {1'b0, op.a} + {1'b0, op.b} + {8'd0, op.cin};
	assign diff = {1'b0, op.a} - {1'b0, op.b} - {8'd0, op.cin};

	always_comb begin
		r = op.a;
		v = 1'b0;
		c = 1'b0;
		case (op.mode)
			MODE_ADD: begin
				r = sum[7:0];
				v = (op.a[7] ^ r[7]) & (op.b[7] ^ r[7]);
				c = sum[8];
			end
			MODE_SUB: begin
				r = diff[7:0];
				v = (op.a[7] ^ op.b[7]) & (op.a[7] ^ r[7]);
				c = diff[8];
			end
			MODE_AND: r = op.a & op.b;
			MODE_OR:  r = op.a | op.b;
			MODE_XOR: r = op.a ^ op.b;
			MODE_COM: r = ~op.a;
			MODE_NEG: begin
				r = 8'd0 - op.a;
				v = (op.a == MOST_NEG);
				c = |op.a;
			end
			MODE_SHL, MODE_ROL: begin
				// rol feeds the old top bit back in; shl shifts in zero
				r = {op.a[6:0], (op.mode == MODE_ROL) & op.a[7]};
				v = op.a[7] ^ op.a[6];
				c = op.a[7];
			end
			MODE_ASR: begin
				r = {op.a[7], op.a[7:1]};
				c = op.a[0];
			end
			MODE_ROR: begin
				r = {op.a[0], op.a[7:1]};
				c = op.a[0];
			end
			default: r = op.a;  // test and unused codes pass a through
		endcase
	end

	always_comb begin
		res.result                 = r;
		res.flags                  = '0;
		res.flags[FLAG_N_BIT]      = r[7];
		res.flags[FLAG_Z_BIT]      = (r == 8'd0);
		res.flags[FLAG_V_BIT]      = v;
		res.flags[FLAG_C_BIT]      = c;
	end

endmodule

`default_nettype wire

/* sv/alu8_nzvc_flags_unit.sv */
// 8-bit ALU with N/Z/V/C flags and no architectural state. A beat on the input
// channel carries mode, operand_a, operand_b and carry_in; exactly one result
// beat (result, flags = {N,Z,V,C}) follows for each, in order. The datapath is
// an input register, one level of operation logic and a result register; a
// result is offered once its beat has gone through both registers, and a new
// beat can be taken every cycle while the output is not stalled. in_ready drops
// only when both registers are full and the result is not being taken.
`default_nettype none

`include "alu8_nzvc_flags_unit_macros.svh"

module alu8_nzvc_flags_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [3:0] mode,
	input  logic [7:0] operand_a,
	input  logic [7:0] operand_b,
	input  logic       carry_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] result,
	output logic [3:0] flags
);
	import alu8nzvc_pkg::*;

	logic v_s1;
	logic v_s2;
	op_t  op_s1;
	res_t res_comb;
	res_t res_s2;
	logic adv_s2;

	assign adv_s2   = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (adv_s2)   v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= '{mode: mode, a: operand_a, b: operand_b, cin: carry_in};
		end
		if (v_s1 && adv_s2) begin
			res_s2 <= res_comb;
		end
	end

	alu8nzvc_core u_core (
		.op  (op_s1),
		.res (res_comb)
	);

	assign out_valid = v_s2;
	assign result    = res_s2.result;
	assign flags     = res_s2.flags;

	`A8_ASSERT_NOW(a_z_flag, out_valid, flags[FLAG_Z_BIT] == (result == 8'd0))
	`A8_ASSERT_NOW(a_n_flag, out_valid, flags[FLAG_N_BIT] == result[7])
	`A8_ASSERT_NOW(a_stall_only_full, !in_ready, v_s1 && out_valid && !out_ready)
	`A8_ASSERT_NEXT(a_beat_lands, in_valid && in_ready, v_s1)

endmodule

`default_nettype wire
